// ===== sv/atrm_pkg.sv =====
// Shared types and fixed field widths for the autoscaled trace row mapper.
package atrm_pkg;

    localparam int SAMPLE_W = 12;
    localparam int GAP_W    = 7;
    localparam int ROW_W    = 6;
    localparam int PAIR_W   = 6;

    localparam logic [GAP_W-1:0] GAP_RESET = 7'd5;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_SCAN,
        ST_SCAN_END,
        ST_SCALE_LD,
        ST_DIV_SCALE,
        ST_SCALE_FIX,
        ST_COL_RD,
        ST_COL_LD,
        ST_DIV_ROW,
        ST_COL_DONE
    } t_state;

endpackage

// ===== sv/atrm_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
module atrm_ram #(
    parameter int WIDTH = 12,
    parameter int DEPTH = 128
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ===== sv/autoscaled_trace_row_mapper_core.sv =====
// Autoscaled trace row mapper: each accepted sample is written into a ring of COLUMNS
// entries at the current write column, the ring is scanned for min and max, and every
// column is mapped to a display row (max - value) / scale, scale = max(1, (max - min) / ROWS),
// clamped to ROWS - 1. The blank_gap columns after the write column are flagged hidden.
// Results leave as (COLUMNS + 1) / 2 column-pair transactions, the final one marked last,
// and the write column then advances with wrap. Run time is set by the single restoring divide
// unit that produces one quotient bit per cycle, first for the scale and then for every column,
// and by the single ring read port. Columns whose row clamps skip the divide. Output
// back-pressure adds stall cycles per pair. The ring reads as zero until a column is written.
module autoscaled_trace_row_mapper_core #(
    parameter int COLUMNS     = 128,
    parameter int ROWS        = 64,
    parameter int SAMPLE_BITS = 12
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_we,
    input  logic [atrm_pkg::GAP_W-1:0]    i_cfg_wdata,
    input  logic                          i_in_valid,
    output logic                          o_in_ready,
    input  logic [atrm_pkg::SAMPLE_W-1:0] i_sample,
    output logic                          o_out_valid,
    input  logic                          i_out_ready,
    output logic [atrm_pkg::PAIR_W-1:0]   o_pair_index,
    output logic [atrm_pkg::ROW_W-1:0]    o_row_even,
    output logic [atrm_pkg::ROW_W-1:0]    o_row_odd,
    output logic                          o_shown_even,
    output logic                          o_shown_odd,
    output logic                          o_last
);
    import atrm_pkg::*;

    localparam int CB    = $clog2(COLUMNS);
    localparam int CW    = $clog2(COLUMNS + 1);
    localparam int SB    = SAMPLE_BITS;
    localparam int QB    = $clog2(ROWS);
    localparam int STW   = $clog2(SAMPLE_BITS + 1);
    localparam int PAIRS = (COLUMNS + 1) / 2;

    t_state r_state, n_state;

    logic [CW-1:0]      r_col, n_col;
    logic [CB-1:0]      r_wc, n_wc;
    logic [GAP_W-1:0]   r_gap, n_gap;
    logic [COLUMNS-1:0] r_ring_vld, n_ring_vld;
    logic               r_pend, n_pend;
    logic [STW-1:0]     r_step, n_step;
    logic               r_out_valid, n_out_valid;

    logic               r_rd_vld;
    logic [SB-1:0]      r_min, n_min;
    logic [SB-1:0]      r_max, n_max;
    logic [SB-1:0]      r_acc, n_acc;
    logic [SB-1:0]      r_num, n_num;
    logic [SB-1:0]      r_div, n_div;
    logic               r_ovf, n_ovf;
    logic [ROW_W-1:0]   r_row_even, n_row_even;
    logic               r_shown_even, n_shown_even;
    logic [PAIR_W-1:0]  r_pair_index, n_pair_index;
    logic [ROW_W-1:0]   r_out_row_even, n_out_row_even;
    logic [ROW_W-1:0]   r_out_row_odd, n_out_row_odd;
    logic               r_out_shown_even, n_out_shown_even;
    logic               r_out_shown_odd, n_out_shown_odd;
    logic               r_out_last, n_out_last;

    logic               w_accept;
    logic [CB-1:0]      w_raddr;
    logic [SB-1:0]      w_ram_q;
    logic [SB-1:0]      w_rd_val;
    logic [SB-1:0]      w_num_row;
    logic [SB:0]        w_trial;
    logic [SB+1:0]      w_diff;
    logic               w_ge;
    logic [QB-1:0]      w_q;
    logic               w_miss;
    logic [ROW_W-1:0]   w_row;
    logic [CB:0]        w_dsum;
    logic [CB:0]        w_dist;
    logic               w_shown;
    logic               w_pair_last;

    assign o_in_ready = (r_state == ST_IDLE);
    assign w_accept   = i_in_valid && o_in_ready;
    assign w_raddr    = r_col[CB-1:0];

    atrm_ram #(
        .WIDTH (SB),
        .DEPTH (COLUMNS)
    ) u_ring (
        .i_clk   (i_clk),
        .i_we    (w_accept),
        .i_waddr (r_wc),
        .i_wdata (SB'(i_sample)),
        .i_raddr (w_raddr),
        .o_rdata (w_ram_q)
    );

    // Never-written columns read as zero.
    assign w_rd_val  = r_rd_vld ? w_ram_q : '0;
    assign w_num_row = r_max - w_rd_val;

    // Shared divide unit: one restoring step, or the clamp test on the high part.
    always_comb begin
        if (r_state == ST_COL_LD) begin
            w_trial = (SB+1)'(w_num_row >> QB);
        end else begin
            w_trial = {r_acc, r_num[SB-1]};
        end
        w_diff = {1'b0, w_trial} - (SB+2)'(r_div);
        w_ge   = !w_diff[SB+1];
    end

    assign w_q    = r_num[QB-1:0];
    assign w_miss = (r_col == CW'(COLUMNS));

    always_comb begin
        if (w_miss) begin
            w_row = '0;
        end else if (r_ovf || ((QB+1)'(w_q) >= (QB+1)'(ROWS))) begin
            w_row = ROW_W'(ROWS - 1);
        end else begin
            w_row = ROW_W'(w_q);
        end
    end

    // Columns between the write column and this one, modulo COLUMNS.
    always_comb begin
        w_dsum = (CB+1)'(r_col[CB-1:0]) + (CB+1)'(COLUMNS) - (CB+1)'(r_wc) - (CB+1)'(1);
        if (w_dsum >= (CB+1)'(COLUMNS)) begin
            w_dist = w_dsum - (CB+1)'(COLUMNS);
        end else begin
            w_dist = w_dsum;
        end
        w_shown = !w_miss && !((GAP_W+1)'(w_dist) < (GAP_W+1)'(r_gap));
    end

    assign w_pair_last = ((r_col >> 1) == CW'(PAIRS - 1));

    always_comb begin
        n_state          = r_state;
        n_col            = r_col;
        n_wc             = r_wc;
        n_gap            = i_cfg_we ? i_cfg_wdata : r_gap;
        n_ring_vld       = r_ring_vld;
        n_pend           = 1'b0;
        n_step           = r_step;
        n_out_valid      = r_out_valid && !i_out_ready;
        n_min            = r_min;
        n_max            = r_max;
        n_acc            = r_acc;
        n_num            = r_num;
        n_div            = r_div;
        n_ovf            = r_ovf;
        n_row_even       = r_row_even;
        n_shown_even     = r_shown_even;
        n_pair_index     = r_pair_index;
        n_out_row_even   = r_out_row_even;
        n_out_row_odd    = r_out_row_odd;
        n_out_shown_even = r_out_shown_even;
        n_out_shown_odd  = r_out_shown_odd;
        n_out_last       = r_out_last;

        // Fold the word read in the previous cycle into min and max.
        if (r_pend) begin
            if (w_rd_val < r_min) begin
                n_min = w_rd_val;
            end
            if (w_rd_val > r_max) begin
                n_max = w_rd_val;
            end
        end

        unique case (r_state)
            ST_IDLE: begin
                if (w_accept) begin
                    n_ring_vld[r_wc] = 1'b1;
                    n_col            = '0;
                    n_min            = '1;
                    n_max            = '0;
                    n_state          = ST_SCAN;
                end
            end
            ST_SCAN: begin
                n_pend = 1'b1;
                if (r_col == CW'(COLUMNS - 1)) begin
                    n_state = ST_SCAN_END;
                end else begin
                    n_col = r_col + CW'(1);
                end
            end
            ST_SCAN_END: begin
                n_state = ST_SCALE_LD;
            end
            ST_SCALE_LD: begin
                n_num   = r_max - r_min;
                n_acc   = '0;
                n_div   = SB'(ROWS);
                n_step  = STW'(SB);
                n_state = ST_DIV_SCALE;
            end
            ST_DIV_SCALE, ST_DIV_ROW: begin
                n_acc = w_ge ? w_diff[SB-1:0] : w_trial[SB-1:0];
                n_num = {r_num[SB-2:0], w_ge};
                if (r_step == STW'(1)) begin
                    n_state = (r_state == ST_DIV_SCALE) ? ST_SCALE_FIX : ST_COL_DONE;
                end else begin
                    n_step = r_step - STW'(1);
                end
            end
            ST_SCALE_FIX: begin
                // Scale holds in the divisor register for the column pass.
                n_div   = (r_num == '0) ? SB'(1) : r_num;
                n_col   = '0;
                n_state = ST_COL_RD;
            end
            ST_COL_RD: begin
                n_state = w_miss ? ST_COL_DONE : ST_COL_LD;
            end
            ST_COL_LD: begin
                if (w_ge) begin
                    n_ovf   = 1'b1;
                    n_state = ST_COL_DONE;
                end else begin
                    n_ovf   = 1'b0;
                    n_acc   = w_trial[SB-1:0];
                    n_num   = w_num_row << (SB - QB);
                    n_step  = STW'(QB);
                    n_state = ST_DIV_ROW;
                end
            end
            ST_COL_DONE: begin
                if (!r_col[0]) begin
                    n_row_even   = w_row;
                    n_shown_even = w_shown;
                    n_col        = r_col + CW'(1);
                    n_state      = ST_COL_RD;
                end else if (!r_out_valid || i_out_ready) begin
                    n_out_valid      = 1'b1;
                    n_pair_index     = PAIR_W'(r_col >> 1);
                    n_out_row_even   = r_row_even;
                    n_out_shown_even = r_shown_even;
                    n_out_row_odd    = w_row;
                    n_out_shown_odd  = w_shown;
                    n_out_last       = w_pair_last;
                    if (w_pair_last) begin
                        n_wc    = (r_wc == CB'(COLUMNS - 1)) ? '0 : r_wc + CB'(1);
                        n_state = ST_IDLE;
                    end else begin
                        n_col   = r_col + CW'(1);
                        n_state = ST_COL_RD;
                    end
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_col       <= '0;
            r_wc        <= '0;
            r_gap       <= GAP_RESET;
            r_ring_vld  <= '0;
            r_pend      <= 1'b0;
            r_step      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_col       <= n_col;
            r_wc        <= n_wc;
            r_gap       <= n_gap;
            r_ring_vld  <= n_ring_vld;
            r_pend      <= n_pend;
            r_step      <= n_step;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rd_vld         <= r_ring_vld[w_raddr];
        r_min            <= n_min;
        r_max            <= n_max;
        r_acc            <= n_acc;
        r_num            <= n_num;
        r_div            <= n_div;
        r_ovf            <= n_ovf;
        r_row_even       <= n_row_even;
        r_shown_even     <= n_shown_even;
        r_pair_index     <= n_pair_index;
        r_out_row_even   <= n_out_row_even;
        r_out_row_odd    <= n_out_row_odd;
        r_out_shown_even <= n_out_shown_even;
        r_out_shown_odd  <= n_out_shown_odd;
        r_out_last       <= n_out_last;
    end

    assign o_out_valid  = r_out_valid;
    assign o_pair_index = r_pair_index;
    assign o_row_even   = r_out_row_even;
    assign o_row_odd    = r_out_row_odd;
    assign o_shown_even = r_out_shown_even;
    assign o_shown_odd  = r_out_shown_odd;
    assign o_last       = r_out_last;

endmodule

// ===== sv/atrm_checker.sv =====
// Port-level checks for the autoscaled trace row mapper, bound to the top level.
module atrm_checker (
    input logic                          i_clk,
    input logic                          i_rst_n,
    input logic                          i_cfg_we,
    input logic [atrm_pkg::GAP_W-1:0]    i_cfg_wdata,
    input logic                          i_in_valid,
    input logic                          o_in_ready,
    input logic [atrm_pkg::SAMPLE_W-1:0] i_sample,
    input logic                          o_out_valid,
    input logic                          i_out_ready,
    input logic [atrm_pkg::PAIR_W-1:0]   o_pair_index,
    input logic [atrm_pkg::ROW_W-1:0]    o_row_even,
    input logic [atrm_pkg::ROW_W-1:0]    o_row_odd,
    input logic                          o_shown_even,
    input logic                          o_shown_odd,
    input logic                          o_last
);

    // Not ready again directly after a sample is taken.
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready) |=> !o_in_ready)
        else $error("ready right after a sample transaction");

    // No new sample while pairs of the current run are still to come.
    a_busy_mid_run: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !o_last) |-> !o_in_ready)
        else $error("ready in the middle of a run");

    // Nothing follows the final pair directly.
    a_gap_after_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && i_out_ready && o_last) |=> !o_out_valid)
        else $error("result right after the final pair");

    // Hold a stalled result.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !i_out_ready) |=> (o_out_valid && $stable(o_pair_index)
            && $stable(o_row_even) && $stable(o_row_odd) && $stable(o_shown_even)
            && $stable(o_shown_odd) && $stable(o_last)))
        else $error("stalled result changed");

endmodule

bind autoscaled_trace_row_mapper_core atrm_checker u_atrm_checker (.*);
